[sv/world_to_screen_projection_defines.svh]
// Shared assertion macros for the projection block checkers.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Same-cycle implication.
`define W2S_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define W2S_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[sv/w2s_pkg.sv]
package w2s_pkg;

    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int COORD_W           = 32;
    localparam int CFG_W             = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int SIZE_W            = 14;
    // ndc magnitude saturates below 2^NDC_LIMIT_BITS
    localparam int NDC_LIMIT_BITS    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_COL0_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL0_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL1_01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL1_23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL3_01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COL3_23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

    localparam logic [CFG_W-1:0]  COL0_01_RST = 64'h0000_0001_0000_0000;
    localparam logic [CFG_W-1:0]  COL0_23_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0]  COL1_01_RST = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0]  COL1_23_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0]  COL3_01_RST = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0]  COL3_23_RST = 64'h0001_0000_0000_0000;
    localparam logic [SIZE_W-1:0] WIDTH_RST   = 14'd1280;
    localparam logic [SIZE_W-1:0] HEIGHT_RST  = 14'd720;

    localparam logic signed [COORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] world_x;
        logic signed [COORD_W-1:0] world_y;
        logic signed [COORD_W-1:0] world_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] screen_x;
        logic signed [COORD_W-1:0] screen_y;
        logic                      visible;
    } out_item_t;

endpackage

[sv/world_to_screen_projection.sv]
// World-to-screen projection: takes one point per clock unless the pipe is held behind a
// waiting result, and returns one screen result per point, in order. The perspective divide
// is a restoring divider unrolled into 40 pipeline stages that each retire one quotient
// bit for both x and y; ahead of it sit the 3x3 multiplier stage, two adder stages, the
// sign/magnitude stage and the divider setup, and behind it the viewport offset, the size
// multiply and the saturating output register. The output register decouples the two
// sides: while a result waits, new requests are still taken until the pipe's last
// stage is full. Matrix and viewport registers are sampled by the pipe directly, so write
// them only while no request is in flight.
module world_to_screen_projection #(
    parameter int FRAC_BITS = w2s_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [w2s_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [w2s_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  w2s_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output w2s_pkg::out_item_t             out_data
);

    localparam int CW    = w2s_pkg::COORD_W;
    localparam int PSH_W = 2 * CW - FRAC_BITS;        // floored product
    localparam int ACC_W = PSH_W + 2;                 // sum of three products and offset
    localparam int LIM   = w2s_pkg::NDC_LIMIT_BITS;
    localparam int QI_W  = LIM - FRAC_BITS;           // integer quotient bits
    localparam int V_W   = LIM + 2;
    localparam int SZ_W  = w2s_pkg::SIZE_W + 1;
    localparam int SP_W  = V_W + SZ_W;
    localparam int NSTG  = LIM + 7;                   // stages ahead of the output register

    localparam logic signed [V_W-1:0] ONE_V = V_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
        logic sat_x;
        logic sat_y;
    } div_side_t;

    // configuration
    logic [w2s_pkg::CFG_W-1:0]  mat_lo_reg [3];   // rows 0,1 of columns 0,1,3
    logic [w2s_pkg::CFG_W-1:0]  mat_hi_reg [3];   // rows 2,3
    logic [w2s_pkg::SIZE_W-1:0] width_reg;
    logic [w2s_pkg::SIZE_W-1:0] height_reg;

    // control
    logic            en;
    logic [NSTG-1:0] vld_reg;
    logic            out_valid_reg;
    logic            out_load;

    // stage 1..3
    logic signed [2*CW-1:0]  prod_full [3][3];
    logic signed [PSH_W-1:0] prod_next [3][3];
    logic signed [PSH_W-1:0] prod_reg  [3][3];
    logic signed [ACC_W-1:0] sum_a_next [3];
    logic signed [ACC_W-1:0] sum_b_next [3];
    logic signed [ACC_W-1:0] sum_a_reg  [3];
    logic signed [ACC_W-1:0] sum_b_reg  [3];
    logic signed [ACC_W-1:0] clip_next  [3];
    logic signed [ACC_W-1:0] clip_reg   [3];

    // stage 4
    logic [ACC_W-1:0] mag_next [2];
    logic [ACC_W-1:0] mag_reg  [2];
    logic [ACC_W-1:0] den4_next;
    logic [ACC_W-1:0] den4_reg;
    div_side_t        side4_next;
    div_side_t        side4_reg;

    // divider: index 0 is the setup stage, index LIM the last quotient bit
    logic [ACC_W+QI_W-1:0] sat_lhs [2];
    logic [ACC_W+QI_W-1:0] sat_rhs;
    logic [ACC_W-1:0] rem0_next [2];
    logic [LIM-1:0]   quo0_next [2];
    div_side_t        side0_next;
    logic [ACC_W-1:0] rem_reg  [LIM+1][2];
    logic [LIM-1:0]   quo_reg  [LIM+1][2];
    logic [ACC_W-1:0] den_reg  [LIM+1];
    div_side_t        side_reg [LIM+1];
    logic [ACC_W:0]   trial    [LIM][2];
    logic [ACC_W:0]   diff     [LIM][2];
    logic             ge       [LIM][2];
    logic [ACC_W-1:0] rem_next [LIM][2];
    logic [LIM-1:0]   quo_next [LIM][2];

    // back end
    logic [LIM-1:0]          q_sel [2];
    logic signed [V_W-1:0]   v_next [2];
    logic signed [V_W-1:0]   v_reg  [2];
    logic                    vis_p1_reg;
    logic signed [SP_W-1:0]  sp_next [2];
    logic signed [SP_W-1:0]  sp_reg  [2];
    logic                    vis_p2_reg;
    logic [SP_W-33:0]        sp_hi [2];
    logic signed [CW-1:0]    scr [2];
    w2s_pkg::out_item_t      out_next;
    w2s_pkg::out_item_t      out_data_reg;

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_lo_reg[0] <= w2s_pkg::COL0_01_RST;
            mat_hi_reg[0] <= w2s_pkg::COL0_23_RST;
            mat_lo_reg[1] <= w2s_pkg::COL1_01_RST;
            mat_hi_reg[1] <= w2s_pkg::COL1_23_RST;
            mat_lo_reg[2] <= w2s_pkg::COL3_01_RST;
            mat_hi_reg[2] <= w2s_pkg::COL3_23_RST;
            width_reg     <= w2s_pkg::WIDTH_RST;
            height_reg    <= w2s_pkg::HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                w2s_pkg::REG_COL0_01: mat_lo_reg[0] <= cfg_data;
                w2s_pkg::REG_COL0_23: mat_hi_reg[0] <= cfg_data;
                w2s_pkg::REG_COL1_01: mat_lo_reg[1] <= cfg_data;
                w2s_pkg::REG_COL1_23: mat_hi_reg[1] <= cfg_data;
                w2s_pkg::REG_COL3_01: mat_lo_reg[2] <= cfg_data;
                w2s_pkg::REG_COL3_23: mat_hi_reg[2] <= cfg_data;
                w2s_pkg::REG_WIDTH:   width_reg  <= cfg_data[w2s_pkg::SIZE_W-1:0];
                w2s_pkg::REG_HEIGHT:  height_reg <= cfg_data[w2s_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves unless its last stage is stuck behind a held result
    assign en       = ~vld_reg[NSTG-1] | ~out_valid_reg | out_ready;
    assign out_load = ~out_valid_reg | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NSTG-2:0], in_valid};
            end
            if (out_load)
            begin
                out_valid_reg <= vld_reg[NSTG-1];
            end
        end
    end

    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod_full[c][0] = in_data.world_x * $signed(mat_lo_reg[c][CW-1:0]);
            prod_full[c][1] = in_data.world_y * $signed(mat_lo_reg[c][2*CW-1:CW]);
            prod_full[c][2] = in_data.world_z * $signed(mat_hi_reg[c][CW-1:0]);
            for (int r = 0; r < 3; r++)
            begin
                // arithmetic drop of the fraction bits = floor
                prod_next[c][r] = prod_full[c][r][2*CW-1:FRAC_BITS];
            end
            sum_a_next[c] = {{2{prod_reg[c][0][PSH_W-1]}}, prod_reg[c][0]}
                          + {{2{prod_reg[c][1][PSH_W-1]}}, prod_reg[c][1]};
            sum_b_next[c] = {{2{prod_reg[c][2][PSH_W-1]}}, prod_reg[c][2]}
                          + {{(ACC_W-CW){mat_hi_reg[c][2*CW-1]}}, mat_hi_reg[c][2*CW-1:CW]};
            clip_next[c]  = sum_a_reg[c] + sum_b_reg[c];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag_next[i] = clip_reg[i][ACC_W-1] ? ACC_W'(-clip_reg[i]) : clip_reg[i];
        end
        den4_next  = clip_reg[2];
        side4_next = '{vis:   ~clip_reg[2][ACC_W-1] & (|clip_reg[2]),
                       neg_x: clip_reg[0][ACC_W-1],
                       neg_y: clip_reg[1][ACC_W-1],
                       sat_x: 1'b0,
                       sat_y: 1'b0};
    end

    // divider setup: saturate when mag >= den * 2^QI_W
    always_comb
    begin
        sat_rhs = {den4_reg, {QI_W{1'b0}}};
        for (int i = 0; i < 2; i++)
        begin
            sat_lhs[i]   = {{QI_W{1'b0}}, mag_reg[i]};
            rem0_next[i] = {{QI_W{1'b0}}, mag_reg[i][ACC_W-1:QI_W]};
            quo0_next[i] = {mag_reg[i][QI_W-1:0], {FRAC_BITS{1'b0}}};
        end
        side0_next       = side4_reg;
        side0_next.sat_x = sat_lhs[0] >= sat_rhs;
        side0_next.sat_y = sat_lhs[1] >= sat_rhs;
    end

    // one restoring step per stage; quotient bits shift in behind the dividend bits
    always_comb
    begin
        for (int k = 0; k < LIM; k++)
        begin
            for (int i = 0; i < 2; i++)
            begin
                trial[k][i]    = {rem_reg[k][i], quo_reg[k][i][LIM-1]};
                diff[k][i]     = trial[k][i] - {1'b0, den_reg[k]};
                ge[k][i]       = trial[k][i] >= {1'b0, den_reg[k]};
                rem_next[k][i] = ge[k][i] ? diff[k][i][ACC_W-1:0] : trial[k][i][ACC_W-1:0];
                quo_next[k][i] = {quo_reg[k][i][LIM-2:0], ge[k][i]};
            end
        end
    end

    // viewport: x = 1 + ndc_x, y = 1 - ndc_y, then times size, halve, saturate
    always_comb
    begin
        q_sel[0] = side_reg[LIM].sat_x ? {LIM{1'b1}} : quo_reg[LIM][0];
        q_sel[1] = side_reg[LIM].sat_y ? {LIM{1'b1}} : quo_reg[LIM][1];
        v_next[0] = side_reg[LIM].neg_x ? ONE_V - $signed({2'b00, q_sel[0]})
                                        : ONE_V + $signed({2'b00, q_sel[0]});
        v_next[1] = side_reg[LIM].neg_y ? ONE_V + $signed({2'b00, q_sel[1]})
                                        : ONE_V - $signed({2'b00, q_sel[1]});
        sp_next[0] = v_reg[0] * $signed({1'b0, width_reg});
        sp_next[1] = v_reg[1] * $signed({1'b0, height_reg});
        for (int i = 0; i < 2; i++)
        begin
            sp_hi[i] = sp_reg[i][SP_W-1:32];
            if ((&sp_hi[i]) || !(|sp_hi[i]))
            begin
                scr[i] = sp_reg[i][32:1];
            end
            else
            begin
                scr[i] = sp_reg[i][SP_W-1] ? w2s_pkg::SAT_MIN : w2s_pkg::SAT_MAX;
            end
        end
        out_next.screen_x = vis_p2_reg ? scr[0] : '0;
        out_next.screen_y = vis_p2_reg ? scr[1] : '0;
        out_next.visible  = vis_p2_reg;
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            clip_reg  <= clip_next;
            mag_reg   <= mag_next;
            den4_reg  <= den4_next;
            side4_reg <= side4_next;
            rem_reg[0]  <= rem0_next;
            quo_reg[0]  <= quo0_next;
            den_reg[0]  <= den4_reg;
            side_reg[0] <= side0_next;
            for (int k = 0; k < LIM; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                quo_reg[k+1]  <= quo_next[k];
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            v_reg      <= v_next;
            vis_p1_reg <= side_reg[LIM].vis;
            sp_reg     <= sp_next;
            vis_p2_reg <= vis_p1_reg;
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/w2s_checker.sv]
`include "world_to_screen_projection_defines.svh"

module w2s_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input w2s_pkg::out_item_t out_data
);

    // requests accepted but not yet delivered
    logic [7:0] pend_reg;
    logic [7:0] pend_next;

    always_comb
    begin
        pend_next = pend_reg + {7'd0, in_valid & in_ready} - {7'd0, out_valid & out_ready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 8'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `W2S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
    `W2S_ASSERT_IMPL(a_hidden_zero, out_valid && !out_data.visible, out_data.screen_x == 32'sd0 && out_data.screen_y == 32'sd0, "point behind camera with nonzero screen position")
    `W2S_ASSERT_IMPL(a_no_phantom, out_valid, pend_reg != 8'd0, "result without a pending request")
    `W2S_ASSERT_IMPL(a_ready_when_empty, !out_valid, in_ready, "input blocked while output is empty")

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/world_to_screen_projection_tb.sv]
module world_to_screen_projection_tb;

    localparam int FRAC        = w2s_pkg::FRAC_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = w2s_pkg::NDC_LIMIT_BITS + 20;

    localparam logic signed [w2s_pkg::COORD_W-1:0] FIX_ONE     = 32'sh0001_0000;
    localparam logic signed [w2s_pkg::COORD_W-1:0] FIX_NEG_ONE = 32'shFFFF_0000;

    typedef struct {
        bit                                is_reg;
        logic [w2s_pkg::CFG_IDX_W-1:0]     idx;
        logic [w2s_pkg::CFG_W-1:0]         val;
        w2s_pkg::in_item_t                 pt;
        bit                                pinned;
        w2s_pkg::out_item_t                want;
    } script_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [w2s_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [w2s_pkg::CFG_W-1:0]      cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    w2s_pkg::in_item_t              in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    w2s_pkg::out_item_t             out_data;

    // shadow copy of the block's registers
    logic [w2s_pkg::CFG_W-1:0]      matrix [0:5];
    logic [w2s_pkg::SIZE_W-1:0]     view_w = w2s_pkg::WIDTH_RST;
    logic [w2s_pkg::SIZE_W-1:0]     view_h = w2s_pkg::HEIGHT_RST;

    w2s_pkg::out_item_t             pending_screen [$];
    int                             mismatches = 0;
    int                             cycle_count = 0;
    int                             burst_left = 0;
    bit                             steady = 1'b0;

    int                             ready_cycle = 0;
    int                             ready_mode = 0;
    int                             stall_left = 0;

    world_to_screen_projection DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // ---------------- predictor ----------------

    function automatic longint column_sum(longint x, longint y, longint z,
                                          logic [w2s_pkg::CFG_W-1:0] r01,
                                          logic [w2s_pkg::CFG_W-1:0] r23);
        longint acc;
        acc = (x * longint'($signed(r01[31:0]))) >>> FRAC;
        acc += (y * longint'($signed(r01[63:32]))) >>> FRAC;
        acc += (z * longint'($signed(r23[31:0]))) >>> FRAC;
        acc += longint'($signed(r23[63:32]));
        return acc;
    endfunction

    // num * 2^FRAC / w, magnitude truncated, clamped below 2^NDC_LIMIT_BITS
    function automatic longint ndc_quot(longint num, longint w);
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] q;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        den = 64'(w);
        q = mag / den;
        if (q >= (64'd1 << (w2s_pkg::NDC_LIMIT_BITS - FRAC)))
            q = (64'd1 << w2s_pkg::NDC_LIMIT_BITS) - 64'd1;
        else
            q = (mag << FRAC) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [w2s_pkg::COORD_W-1:0] to_pixels(
            longint v, logic [w2s_pkg::SIZE_W-1:0] size);
        longint p;
        p = (v * longint'(size)) >>> 1;
        if (p > longint'(w2s_pkg::SAT_MAX))
            p = longint'(w2s_pkg::SAT_MAX);
        else if (p < longint'(w2s_pkg::SAT_MIN))
            p = longint'(w2s_pkg::SAT_MIN);
        return p[31:0];
    endfunction

    function automatic w2s_pkg::out_item_t project_point(w2s_pkg::in_item_t pt);
        longint             x;
        longint             y;
        longint             z;
        longint             cx;
        longint             cy;
        longint             cw;
        longint             one;
        w2s_pkg::out_item_t r;
        x = pt.world_x;
        y = pt.world_y;
        z = pt.world_z;
        one = longint'(1) << FRAC;
        cx = column_sum(x, y, z, matrix[w2s_pkg::REG_COL0_01], matrix[w2s_pkg::REG_COL0_23]);
        cy = column_sum(x, y, z, matrix[w2s_pkg::REG_COL1_01], matrix[w2s_pkg::REG_COL1_23]);
        cw = column_sum(x, y, z, matrix[w2s_pkg::REG_COL3_01], matrix[w2s_pkg::REG_COL3_23]);
        r = '0;
        if (cw > 0) begin
            r.screen_x = to_pixels(ndc_quot(cx, cw) + one, view_w);
            r.screen_y = to_pixels(one - ndc_quot(cy, cw), view_h);
            r.visible  = 1'b1;
        end
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic signed [w2s_pkg::COORD_W-1:0] rand_fix(int span);
        logic signed [w2s_pkg::COORD_W-1:0] r;
        r = $urandom;
        return r >>> (31 - span);
    endfunction

    function automatic logic signed [w2s_pkg::COORD_W-1:0] pick_edge();
        case ($urandom_range(0, 5))
            0:       return w2s_pkg::SAT_MIN;
            1:       return w2s_pkg::SAT_MAX;
            2:       return 32'sh0;
            3:       return -32'sh1;
            4:       return FIX_ONE;
            default: return FIX_NEG_ONE;
        endcase
    endfunction

    function automatic logic [w2s_pkg::CFG_W-1:0] edge_size();
        case ($urandom_range(0, 3))
            0:       return 64'd0;
            1:       return 64'd1;
            2:       return 64'd8192;
            default: return 64'd16383;
        endcase
    endfunction

    function automatic w2s_pkg::in_item_t random_point();
        w2s_pkg::in_item_t p;
        int                mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5)
            p = {rand_fix(22), rand_fix(22), rand_fix(22)};
        else if (mode <= 7)
            p = {$urandom, $urandom, $urandom};
        else if (mode == 8)
            p = {rand_fix(16), rand_fix(16), rand_fix(16)};
        else
            p = {pick_edge(), pick_edge(), pick_edge()};
        return p;
    endfunction

    function automatic script_row_t reg_row(logic [w2s_pkg::CFG_IDX_W-1:0] idx,
                                            logic [w2s_pkg::CFG_W-1:0] val);
        script_row_t r;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.pt     = '0;
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic script_row_t pt_row(logic signed [w2s_pkg::COORD_W-1:0] x,
                                           logic signed [w2s_pkg::COORD_W-1:0] y,
                                           logic signed [w2s_pkg::COORD_W-1:0] z);
        script_row_t r;
        r.is_reg = 1'b0;
        r.idx    = w2s_pkg::REG_COL0_01;
        r.val    = '0;
        r.pt     = {x, y, z};
        r.pinned = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic script_row_t pinned_row(logic signed [w2s_pkg::COORD_W-1:0] x,
                                               logic signed [w2s_pkg::COORD_W-1:0] y,
                                               logic signed [w2s_pkg::COORD_W-1:0] z,
                                               logic signed [w2s_pkg::COORD_W-1:0] sx,
                                               logic signed [w2s_pkg::COORD_W-1:0] sy,
                                               logic vis);
        script_row_t r;
        r = pt_row(x, y, z);
        r.pinned = 1'b1;
        r.want   = {sx, sy, vis};
        return r;
    endfunction

    task automatic write_reg(logic [w2s_pkg::CFG_IDX_W-1:0] idx,
                             logic [w2s_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == w2s_pkg::REG_WIDTH)
            view_w = val[w2s_pkg::SIZE_W-1:0];
        else if (idx == w2s_pkg::REG_HEIGHT)
            view_h = val[w2s_pkg::SIZE_W-1:0];
        else
            matrix[idx] = val;
    endtask

    task automatic drain_points();
        in_valid <= 1'b0;
        while (pending_screen.size() != 0)
            @(posedge clk);
    endtask

    // valid stays up across back-to-back requests; a gap lowers it first
    task automatic send_point(w2s_pkg::in_item_t pt, w2s_pkg::out_item_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (steady)
                gap = 0;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(5, 30);
            else
                gap = $urandom_range(0, 3);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= pt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_screen = {pending_screen, want};
    endtask

    task automatic load_setting(int kind);
        logic [w2s_pkg::CFG_W-1:0] vals [0:7];
        case (kind)
            0, 1: begin
                // camera-like: strong diagonal, w follows -z
                vals[w2s_pkg::REG_COL0_01] = {rand_fix(13), rand_fix(18)};
                vals[w2s_pkg::REG_COL0_23] = {rand_fix(20), rand_fix(13)};
                vals[w2s_pkg::REG_COL1_01] = {rand_fix(18), rand_fix(13)};
                vals[w2s_pkg::REG_COL1_23] = {rand_fix(20), rand_fix(13)};
                vals[w2s_pkg::REG_COL3_01] = {rand_fix(10), rand_fix(10)};
                vals[w2s_pkg::REG_COL3_23] = {rand_fix(18),
                                              32'(FIX_NEG_ONE + rand_fix(12))};
                vals[w2s_pkg::REG_WIDTH]   = 64'($urandom_range(1, 8192));
                vals[w2s_pkg::REG_HEIGHT]  = 64'($urandom_range(1, 8192));
            end
            2: begin
                for (int i = 0; i < 8; i++)
                    vals[i] = {$urandom, $urandom};
            end
            default: begin
                for (int i = 0; i < 6; i++)
                    vals[i] = {pick_edge(), pick_edge()};
                vals[w2s_pkg::REG_WIDTH]  = edge_size();
                vals[w2s_pkg::REG_HEIGHT] = edge_size();
            end
        endcase
        drain_points();
        for (int i = 0; i < 8; i++)
            write_reg(w2s_pkg::CFG_IDX_W'(i), vals[i]);
        cfg_write <= 1'b0;
    endtask

    // ---------------- receiver and checker ----------------

    always @(posedge clk) begin
        ready_cycle++;
        if (ready_cycle % 300 == 0)
            ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ((ready_cycle % 9) < 5);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_left = $urandom_range(5, 40);
                end
            end
        endcase
    end

    always @(posedge clk) begin
        w2s_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_screen.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h vis=%b",
                             out_data.screen_x, out_data.screen_y, out_data.visible);
            end else begin
                want = pending_screen.pop_front();
                if (out_data.screen_x !== want.screen_x ||
                    out_data.screen_y !== want.screen_y ||
                    out_data.visible  !== want.visible) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want x=%h y=%h vis=%b got x=%h y=%h vis=%b",
                                 want.screen_x, want.screen_y, want.visible,
                                 out_data.screen_x, out_data.screen_y, out_data.visible);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        script_row_t       script [$];
        bit                cfg_open;
        w2s_pkg::in_item_t pt;

        cfg_open = 1'b0;
        matrix[w2s_pkg::REG_COL0_01] = w2s_pkg::COL0_01_RST;
        matrix[w2s_pkg::REG_COL0_23] = w2s_pkg::COL0_23_RST;
        matrix[w2s_pkg::REG_COL1_01] = w2s_pkg::COL1_01_RST;
        matrix[w2s_pkg::REG_COL1_23] = w2s_pkg::COL1_23_RST;
        matrix[w2s_pkg::REG_COL3_01] = w2s_pkg::COL3_01_RST;
        matrix[w2s_pkg::REG_COL3_23] = w2s_pkg::COL3_23_RST;

        script = {
            // reset matrix: w is 1.0, origin lands mid-screen
            pinned_row(32'sh0, 32'sh0, 32'sh0, 32'sh0280_0000, 32'sh0168_0000, 1'b1),
            pt_row(w2s_pkg::SAT_MAX, w2s_pkg::SAT_MAX, w2s_pkg::SAT_MAX),
            pt_row(w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN),
            pt_row(FIX_ONE, FIX_NEG_ONE, 32'sh1234_5678),
            pt_row(w2s_pkg::SAT_MIN, w2s_pkg::SAT_MAX, 32'sh0),
            // w = -z, x and y pass straight through
            reg_row(w2s_pkg::REG_COL0_01, 64'h0000_0000_0001_0000),
            reg_row(w2s_pkg::REG_COL3_23, 64'h0000_0000_FFFF_0000),
            pinned_row(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0),
            pinned_row(FIX_ONE, FIX_ONE, FIX_ONE, 32'sh0, 32'sh0, 1'b0),
            pinned_row(FIX_ONE, FIX_ONE, FIX_NEG_ONE, 32'sh0500_0000, 32'sh0, 1'b1),
            pt_row(32'sh0002_0000, 32'shFFFD_0000, 32'shFFFF_8000),
            // tiny w: divide saturates; then a very large w and a negative w
            pt_row(w2s_pkg::SAT_MAX, w2s_pkg::SAT_MIN, -32'sh1),
            pt_row(w2s_pkg::SAT_MIN, w2s_pkg::SAT_MAX, -32'sh1),
            pt_row(32'sh0, 32'sh0, w2s_pkg::SAT_MIN),
            pinned_row(32'sh3039, -32'shD431, w2s_pkg::SAT_MAX, 32'sh0, 32'sh0, 1'b0),
            // zero-size viewport
            reg_row(w2s_pkg::REG_WIDTH, 64'd0),
            reg_row(w2s_pkg::REG_HEIGHT, 64'd0),
            pinned_row(FIX_ONE, FIX_ONE, FIX_NEG_ONE, 32'sh0, 32'sh0, 1'b1),
            pt_row(32'sh0003_0000, 32'sh0004_0000, 32'shFFFE_0000),
            // oversized viewport, upper data bits set
            reg_row(w2s_pkg::REG_WIDTH, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_HEIGHT, 64'd8192),
            pt_row(FIX_ONE, FIX_ONE, FIX_NEG_ONE),
            pt_row(32'shFFFF_4000, 32'sh0000_4000, 32'shFFFD_0000),
            pt_row(w2s_pkg::SAT_MAX, w2s_pkg::SAT_MAX, -32'sh1),
            // all entries -1 lsb
            reg_row(w2s_pkg::REG_COL0_01, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_COL0_23, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_COL1_01, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_COL1_23, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_COL3_01, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_COL3_23, 64'hFFFF_FFFF_FFFF_FFFF),
            reg_row(w2s_pkg::REG_WIDTH, 64'd1),
            reg_row(w2s_pkg::REG_HEIGHT, 64'd1),
            pt_row(w2s_pkg::SAT_MAX, w2s_pkg::SAT_MAX, w2s_pkg::SAT_MAX),
            pt_row(w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN),
            pinned_row(32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 1'b0),
            // most negative entries: largest products
            reg_row(w2s_pkg::REG_COL0_01, 64'h8000_0000_8000_0000),
            reg_row(w2s_pkg::REG_COL0_23, 64'h8000_0000_8000_0000),
            reg_row(w2s_pkg::REG_COL1_01, 64'h8000_0000_8000_0000),
            reg_row(w2s_pkg::REG_COL1_23, 64'h8000_0000_8000_0000),
            reg_row(w2s_pkg::REG_COL3_01, 64'h8000_0000_8000_0000),
            reg_row(w2s_pkg::REG_COL3_23, 64'h8000_0000_8000_0000),
            pt_row(w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN, w2s_pkg::SAT_MIN),
            pt_row(w2s_pkg::SAT_MAX, w2s_pkg::SAT_MIN, 32'sh1)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].is_reg) begin
                if (!cfg_open)
                    drain_points();
                write_reg(script[i].idx, script[i].val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_write <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_point(script[i].pt, script[i].pinned ? script[i].want
                                                          : project_point(script[i].pt));
            end
        end

        for (int ph = 0; ph < 8; ph++) begin
            load_setting(ph % 4);
            steady = (ph == 1 || ph == 5);
            for (int k = 0; k < 250; k++) begin
                if (ph == 2 && k == 125)
                    drain_points();
                pt = random_point();
                send_point(pt, project_point(pt));
            end
        end

        drain_points();
        repeat (SETTLE) @(posedge clk);
        mismatches += pending_screen.size();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/w2s_pkg.sv
sv/world_to_screen_projection.sv
sv/w2s_checker.sv
test/world_to_screen_projection_tb.sv
